>>> rtl/core/bstk_pkg.sv
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared types, constants and ring index helpers for the bounded stack.
// ----------------------------------------------------------------------------
package bstk_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned OUT_CNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_REVERSE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CNT_W:0]    sum_t;

  typedef struct packed {
    logic    wr_en;
    addr_t   wr_addr;
    addr_t   rd_addr;
    status_e status;
    cnt_t    count;
    logic    fwd;
  } ctrl_t;

  function automatic addr_t ring_inc(addr_t a);
    addr_t r;
    if (a == addr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = a + addr_t'(1);
    end
    return r;
  endfunction

  function automatic addr_t ring_dec(addr_t a);
    addr_t r;
    if (a == '0) begin
      r = addr_t'(DEPTH - 1);
    end else begin
      r = a - addr_t'(1);
    end
    return r;
  endfunction

  // sum is below twice the depth
  function automatic addr_t ring_wrap(sum_t s);
    sum_t r;
    if (s >= sum_t'(DEPTH)) begin
      r = s - sum_t'(DEPTH);
    end else begin
      r = s;
    end
    return r[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/core/bstk_mem.sv
// ----------------------------------------------------------------------------
// bstk_mem
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bstk_mem
  import bstk_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  addr_t             wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  addr_t             rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/bstk_ctrl.sv
// ----------------------------------------------------------------------------
// bstk_ctrl
// Base index, fill count, orientation and capacity; decodes each request.
// ----------------------------------------------------------------------------
module bstk_ctrl
  import bstk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [OP_W-1:0]  op_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_capacity_i,
  output ctrl_t            ctrl_o
);

  addr_t             base_q, base_d;
  cnt_t              fill_q, fill_d;
  logic              flip_q, flip_d;
  logic [CAP_W-1:0]  cap_q;
  logic [CMP_W-1:0]  cap_w, eff_cap;
  logic              full, empty;
  op_e               op;
  status_e           status;
  logic              wr_en;
  addr_t             wr_addr;

  assign op      = op_e'(op_i);
  assign cap_w   = CMP_W'(cap_q);
  assign eff_cap = (cap_w > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_w;
  assign full    = CMP_W'(fill_q) >= eff_cap;
  assign empty   = fill_q == '0;

  always_comb begin
    base_d  = base_q;
    fill_d  = fill_q;
    flip_d  = flip_q;
    status  = ST_OK;
    wr_en   = 1'b0;
    wr_addr = ring_wrap(sum_t'(base_q) + sum_t'(fill_q));
    unique case (op)
      OP_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          wr_en  = 1'b1;
          fill_d = fill_q + cnt_t'(1);
          if (flip_q) begin
            base_d  = ring_dec(base_q);
            wr_addr = base_d;
          end
        end
      end
      OP_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          fill_d = fill_q - cnt_t'(1);
          if (flip_q) begin
            base_d = ring_inc(base_q);
          end
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status = ST_EMPTY;
        end
      end
      OP_REVERSE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          flip_d = ~flip_q;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      fill_q <= '0;
      flip_q <= 1'b0;
    end else if (accept_i) begin
      base_q <= base_d;
      fill_q <= fill_d;
      flip_q <= flip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(64);
    end else if (cfg_we_i) begin
      cap_q <= cfg_capacity_i;
    end
  end

  // top slot of the state after this request
  always_comb begin
    ctrl_o.wr_en   = accept_i & wr_en;
    ctrl_o.wr_addr = wr_addr;
    ctrl_o.status  = status;
    ctrl_o.count   = fill_d;
    ctrl_o.fwd     = wr_en;
    if (flip_d) begin
      ctrl_o.rd_addr = base_d;
    end else begin
      ctrl_o.rd_addr = ring_wrap(sum_t'(base_d) + sum_t'(fill_d) - sum_t'(1));
    end
  end

endmodule

>>> rtl/core/bounded_stack_with_reverse.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_reverse
// Bounded LIFO stack of signed words with constant-time reverse.
// ----------------------------------------------------------------------------
// Takes one request (push, pop, peek, reverse) per cycle while in_stall_o is
// low and gives one result item per request, in order: status, top word after
// the request and entry count. A result passes through the registered read of
// the entry store and then the output register; a pushed word is forwarded
// around the store. With the output free the block sustains one item per
// cycle. Capacity is written through the cfg port (reset 64) and no clearing
// pass is needed after reset.
module bounded_stack_with_reverse
  import bstk_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [WORD_W-1:0] push_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ST_W-1:0]          status_o,
  output logic signed [WORD_W-1:0] top_value_o,
  output logic [OUT_CNT_W-1:0]     entry_count_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CAP_W-1:0]         cfg_capacity_i
);

  ctrl_t             ctrl;
  logic              accept;
  logic              advance;
  logic [WORD_W-1:0] rd_data;

  logic              s1_valid_q;
  status_e           s1_status_q;
  cnt_t              s1_count_q;
  logic              s1_fwd_q;
  logic [WORD_W-1:0] s1_word_q;
  logic [WORD_W-1:0] s1_top;

  logic              out_valid_q;
  status_e           out_status_q;
  cnt_t              out_count_q;
  logic [WORD_W-1:0] out_top_q;

  assign advance    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  bstk_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .ctrl_o         (ctrl)
  );

  bstk_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (ctrl.wr_en),
    .wr_addr_i (ctrl.wr_addr),
    .wr_data_i (push_value_i),
    .rd_en_i   (accept),
    .rd_addr_i (ctrl.rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= ctrl.status;
      s1_count_q  <= ctrl.count;
      s1_fwd_q    <= ctrl.fwd;
      s1_word_q   <= push_value_i;
    end
  end

  // pushed word bypasses the store read
  always_comb begin
    if (s1_count_q == '0) begin
      s1_top = '0;
    end else if (s1_fwd_q) begin
      s1_top = s1_word_q;
    end else begin
      s1_top = rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= s1_status_q;
      out_count_q  <= s1_count_q;
      out_top_q    <= s1_top;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign top_value_o   = out_top_q;
  assign entry_count_o = OUT_CNT_W'(out_count_q);

endmodule

>>> rtl/core/bstk_checker.sv
// ----------------------------------------------------------------------------
// bstk_checker
// Port-level checks for the bounded stack, bound to the top level.
// ----------------------------------------------------------------------------
module bstk_checker
  import bstk_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [ST_W-1:0]          status_o,
  input logic signed [WORD_W-1:0] top_value_o,
  input logic [OUT_CNT_W-1:0]     entry_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(top_value_o) && $stable(entry_count_o))
    else $error("stalled result item changed");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> entry_count_o == '0 && top_value_o == '0)
    else $error("empty status with entries or top word");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_count_o == '0 |-> top_value_o == '0)
    else $error("empty stack shows a top word");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= OUT_CNT_W'(DEPTH) && status_o <= ST_EMPTY)
    else $error("entry count or status out of range");

endmodule

bind bounded_stack_with_reverse bstk_checker u_bstk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .top_value_o   (top_value_o),
  .entry_count_o (entry_count_o)
);
